// File: hw/rtl/ccfr_pkg.sv
// ----------------------------------------------------------------------------
// ccfr_pkg
// Shared types, codes and the byte-wide CRC-32 update for the frame receiver.
// ----------------------------------------------------------------------------
package ccfr_pkg;

	localparam int unsigned DataW   = 8;
	localparam int unsigned WordW   = 16;
	localparam int unsigned CrcW    = 32;
	localparam int unsigned VerdW   = 3;
	localparam int unsigned CfgIdxW = 2;
	localparam int unsigned OutDataW = 32;

	localparam logic [CrcW-1:0] CrcPoly = 32'hEDB8_8320;
	localparam logic [CrcW-1:0] CrcInit = 32'hFFFF_FFFF;

	// configuration register indexes
	localparam logic [CfgIdxW-1:0] CFG_START_WORD = 2'd0;
	localparam logic [CfgIdxW-1:0] CFG_END_WORD   = 2'd1;
	localparam logic [CfgIdxW-1:0] CFG_EXP_LENGTH = 2'd2;

	localparam logic [WordW-1:0] StartWordRst = 16'hAA55;
	localparam logic [WordW-1:0] EndWordRst   = 16'h55AA;
	localparam logic [WordW-1:0] ExpLengthRst = 16'd784;

	// result kinds
	localparam logic KIND_PAYLOAD = 1'b0;
	localparam logic KIND_VERDICT = 1'b1;

	// verdict codes
	localparam logic [VerdW-1:0] V_OK        = 3'd0;
	localparam logic [VerdW-1:0] V_BAD_START = 3'd1;
	localparam logic [VerdW-1:0] V_BAD_LEN   = 3'd2;
	localparam logic [VerdW-1:0] V_BAD_END   = 3'd3;
	localparam logic [VerdW-1:0] V_CRC_ERR   = 3'd4;

	typedef struct packed {
		logic [WordW-1:0] start_word;
		logic [WordW-1:0] end_word;
		logic [WordW-1:0] expected_length;
	} cfg_t;

	typedef struct packed {
		logic             kind;
		logic [DataW-1:0] data_byte;
		logic [WordW-1:0] byte_index;
		logic [VerdW-1:0] verdict;
	} res_t;

	// reflected CRC-32, one byte
	function automatic logic [CrcW-1:0] crc_byte(input logic [CrcW-1:0] crc_in,
		input logic [DataW-1:0] b);
		logic [CrcW-1:0] c;
		c = crc_in ^ {{(CrcW-DataW){1'b0}}, b};
		for (int k = 0; k < 8; k++) begin
			c = c[0] ? ((c >> 1) ^ CrcPoly) : (c >> 1);
		end
		return c;
	endfunction

endpackage

// File: hw/rtl/ccfr_parse.sv
// ----------------------------------------------------------------------------
// ccfr_parse
// Frame field parser: start word, length, payload with CRC, CRC, end word.
// ----------------------------------------------------------------------------
module ccfr_parse (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     step,
	input  logic [ccfr_pkg::DataW-1:0] rx_byte,
	input  ccfr_pkg::cfg_t           cfg,
	output logic                     res_valid,
	output ccfr_pkg::res_t           res
);

	localparam logic [2:0] PH_START   = 3'd0;
	localparam logic [2:0] PH_LENGTH  = 3'd1;
	localparam logic [2:0] PH_PAYLOAD = 3'd2;
	localparam logic [2:0] PH_CRC     = 3'd3;
	localparam logic [2:0] PH_END     = 3'd4;

	logic [2:0]                  phase_q, phase_d;
	logic [1:0]                  fbc_q, fbc_d;
	logic [ccfr_pkg::CrcW-1:0]   shift_q, shift_d;
	logic [ccfr_pkg::WordW-1:0]  pcount_q, pcount_d;
	logic [ccfr_pkg::CrcW-1:0]   crc_q, crc_d;

	logic [ccfr_pkg::CrcW-1:0]   shift_ins;
	logic [ccfr_pkg::WordW-1:0]  pcount_inc;
	logic                        emit;

	// drop the new byte into its lane of the field register
	always_comb begin
		for (int i = 0; i < 4; i++) begin
			shift_ins[8*i +: 8] = (fbc_q == 2'(i)) ? rx_byte : shift_q[8*i +: 8];
		end
	end

	assign pcount_inc = pcount_q + 16'd1;

	always_comb begin
		phase_d  = phase_q;
		fbc_d    = fbc_q;
		shift_d  = shift_q;
		pcount_d = pcount_q;
		crc_d    = crc_q;
		emit     = 1'b0;
		res      = '0;
		case (phase_q)
			PH_LENGTH: begin
				if (fbc_q == 2'd0) begin
					shift_d = shift_ins;
					fbc_d   = 2'd1;
				end else begin
					fbc_d   = 2'd0;
					shift_d = '0;
					if (shift_ins[15:0] != cfg.expected_length) begin
						emit        = 1'b1;
						res.kind    = ccfr_pkg::KIND_VERDICT;
						res.verdict = ccfr_pkg::V_BAD_LEN;
					end else begin
						pcount_d = '0;
						crc_d    = ccfr_pkg::CrcInit;
						phase_d  = (shift_ins[15:0] == '0) ? PH_CRC : PH_PAYLOAD;
					end
				end
			end
			PH_PAYLOAD: begin
				emit           = 1'b1;
				res.kind       = ccfr_pkg::KIND_PAYLOAD;
				res.data_byte  = rx_byte;
				res.byte_index = pcount_q;
				crc_d          = ccfr_pkg::crc_byte(crc_q, rx_byte);
				pcount_d       = pcount_inc;
				if (pcount_inc >= cfg.expected_length || pcount_inc == '0) begin
					phase_d = PH_CRC;
					fbc_d   = 2'd0;
					shift_d = '0;
				end
			end
			PH_CRC: begin
				if (fbc_q != 2'd3) begin
					shift_d = shift_ins;
					fbc_d   = fbc_q + 2'd1;
				end else begin
					// fold received CRC against computed; zero on match
					crc_d   = shift_ins ^ ~crc_q;
					shift_d = '0;
					fbc_d   = 2'd0;
					phase_d = PH_END;
				end
			end
			PH_END: begin
				if (fbc_q == 2'd0) begin
					shift_d = shift_ins;
					fbc_d   = 2'd1;
				end else begin
					emit     = 1'b1;
					res.kind = ccfr_pkg::KIND_VERDICT;
					if (shift_ins[15:0] != cfg.end_word) begin
						res.verdict = ccfr_pkg::V_BAD_END;
					end else if (crc_q != '0) begin
						res.verdict = ccfr_pkg::V_CRC_ERR;
					end else begin
						res.verdict = ccfr_pkg::V_OK;
					end
				end
			end
			default: begin
				if (fbc_q == 2'd0) begin
					shift_d = shift_ins;
					fbc_d   = 2'd1;
				end else begin
					fbc_d   = 2'd0;
					shift_d = '0;
					if (shift_ins[15:0] != cfg.start_word) begin
						emit        = 1'b1;
						res.kind    = ccfr_pkg::KIND_VERDICT;
						res.verdict = ccfr_pkg::V_BAD_START;
					end else begin
						phase_d = PH_LENGTH;
					end
				end
			end
		endcase
		// any verdict restarts the hunt
		if (emit && res.kind == ccfr_pkg::KIND_VERDICT) begin
			phase_d  = PH_START;
			fbc_d    = 2'd0;
			shift_d  = '0;
			pcount_d = '0;
			crc_d    = ccfr_pkg::CrcInit;
		end
	end

	assign res_valid = step & emit;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q  <= PH_START;
			fbc_q    <= 2'd0;
			shift_q  <= '0;
			pcount_q <= '0;
			crc_q    <= ccfr_pkg::CrcInit;
		end else if (step) begin
			phase_q  <= phase_d;
			fbc_q    <= fbc_d;
			shift_q  <= shift_d;
			pcount_q <= pcount_d;
			crc_q    <= crc_d;
		end
	end

	a_verdict_rehunt: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && res.kind == ccfr_pkg::KIND_VERDICT |=> phase_q == PH_START && crc_q ==
			ccfr_pkg::CrcInit && pcount_q == '0)
		else $error("verdict did not restart the hunt");

	a_payload_phase: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && res.kind == ccfr_pkg::KIND_PAYLOAD |-> phase_q == PH_PAYLOAD &&
			res.verdict == ccfr_pkg::V_OK)
		else $error("payload item outside payload phase");

	a_payload_count: assert property (@(posedge clk) disable iff (!arst_n)
		step && phase_q == PH_PAYLOAD && phase_d == PH_PAYLOAD |=>
			pcount_q == $past(pcount_q) + 16'd1)
		else $error("payload index did not advance");

endmodule

// File: hw/rtl/ccfr_out_buf.sv
// ----------------------------------------------------------------------------
// ccfr_out_buf
// Two-entry result buffer between the parser and the master stream.
// ----------------------------------------------------------------------------
module ccfr_out_buf (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           push,
	input  ccfr_pkg::res_t push_res,
	output logic           full,
	output logic           out_valid,
	input  logic           out_ready,
	output ccfr_pkg::res_t out_res
);

	ccfr_pkg::res_t mem_q [2];
	logic           wr_ptr_q;
	logic           rd_ptr_q;
	logic [1:0]     count_q;
	logic           pop;

	assign pop       = out_valid & out_ready;
	assign out_valid = count_q != 2'd0;
	assign full      = count_q == 2'd2;
	assign out_res   = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_res;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q  <= 2'd0;
		end else begin
			if (push) begin
				wr_ptr_q <= ~wr_ptr_q;
			end
			if (pop) begin
				rd_ptr_q <= ~rd_ptr_q;
			end
			count_q <= count_q + {1'b0, push} - {1'b0, pop};
		end
	end

	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		!(push && full))
		else $error("result buffer overflow");

	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		count_q != 2'd3)
		else $error("result buffer count out of range");

endmodule

// File: hw/rtl/crc32_checked_frame_receiver_core.sv
// ----------------------------------------------------------------------------
// crc32_checked_frame_receiver_core
// Byte-serial frame receiver with CRC-32 check and per-byte payload output.
// ----------------------------------------------------------------------------
// Usage:
//   s_* stream carries one received byte per item. m_* stream carries results:
//   m_tuser = 0 for a payload byte (data and index in m_tdata), 1 for a frame
//   verdict (code in m_tdata). Only payload bytes and verdicts make results;
//   header, CRC and end-word bytes make none.
//   cfg_* writes start word, end word and expected length; write only while
//   the block is idle. cfg_ready is always high.
// Timing:
//   One item per cycle sustained while m_tready stays high. An accepted byte sits in
//   the input register while the parser (byte-wide CRC update plus field compares)
//   works on it; its result enters a two-entry output buffer when the parser steps,
//   which it does only while the buffer has room, and shows on m_* from there.
// Reset:
//   arst_n clears the parser to hunting the start word, loads the register
//   defaults and empties the buffer. Stalls: when m_tready stays low the
//   buffer fills, the parser holds and s_tready drops after one more byte.
// ----------------------------------------------------------------------------
module crc32_checked_frame_receiver_core (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          s_tvalid,
	output logic                          s_tready,
	input  logic [ccfr_pkg::DataW-1:0]    s_tdata,   // [7:0] rx_byte
	output logic                          m_tvalid,
	input  logic                          m_tready,
	output logic [ccfr_pkg::OutDataW-1:0] m_tdata,   // [7:0] data_byte, [23:8] byte_index,
	                                                 // [26:24] verdict, [31:27] zero
	output logic                          m_tuser,   // [0] kind
	input  logic                          cfg_valid,
	output logic                          cfg_ready,
	input  logic [ccfr_pkg::CfgIdxW-1:0]  cfg_index,
	input  logic [ccfr_pkg::WordW-1:0]    cfg_data
);

	ccfr_pkg::cfg_t              cfg_q;
	logic                        valid_s1;
	logic [ccfr_pkg::DataW-1:0]  byte_s1;
	logic                        buf_full;
	logic                        step;
	logic                        res_valid;
	ccfr_pkg::res_t              res;
	ccfr_pkg::res_t              out_res;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.start_word      <= ccfr_pkg::StartWordRst;
			cfg_q.end_word        <= ccfr_pkg::EndWordRst;
			cfg_q.expected_length <= ccfr_pkg::ExpLengthRst;
		end else if (cfg_valid) begin
			case (cfg_index)
				ccfr_pkg::CFG_START_WORD: cfg_q.start_word      <= cfg_data;
				ccfr_pkg::CFG_END_WORD:   cfg_q.end_word        <= cfg_data;
				ccfr_pkg::CFG_EXP_LENGTH: cfg_q.expected_length <= cfg_data;
				default: ;
			endcase
		end
	end

	// advance the input register whenever the buffer has room
	assign step     = valid_s1 & ~buf_full;
	assign s_tready = ~valid_s1 | step;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			byte_s1 <= s_tdata;
		end
	end

	ccfr_parse u_parse (
		.clk       (clk),
		.arst_n    (arst_n),
		.step      (step),
		.rx_byte   (byte_s1),
		.cfg       (cfg_q),
		.res_valid (res_valid),
		.res       (res)
	);

	ccfr_out_buf u_out_buf (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (res_valid),
		.push_res  (res),
		.full      (buf_full),
		.out_valid (m_tvalid),
		.out_ready (m_tready),
		.out_res   (out_res)
	);

	assign m_tuser = out_res.kind;
	assign m_tdata = {5'd0, out_res.verdict, out_res.byte_index, out_res.data_byte};

endmodule

// File: sim/tb_crc32_checked_frame_receiver_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_crc32_checked_frame_receiver_core
// Feeds framed byte streams (good frames, corrupted fields, noise) through the
// receiver under random stalls on both streams, predicts every payload byte
// and verdict with an in-bench frame parser and compares each output item.
// ----------------------------------------------------------------------------
module tb_crc32_checked_frame_receiver_core;

	localparam int unsigned IdleLimit = 5000;
	localparam int unsigned MaxPay    = 48;
	localparam int unsigned RandItems = 800;
	localparam int unsigned DirRows   = 29;

	typedef enum logic [2:0] {
		PH_HUNT = 3'd0,
		PH_LEN  = 3'd1,
		PH_PAY  = 3'd2,
		PH_CRC  = 3'd3,
		PH_END  = 3'd4
	} phase_e;

	typedef struct packed {
		logic                         cfg_wr;
		logic [ccfr_pkg::CfgIdxW-1:0] reg_idx;
		logic [ccfr_pkg::WordW-1:0]   value;
		logic                         fixed;
		logic                         has_res;
		ccfr_pkg::res_t               res;
	} row_t;

	localparam ccfr_pkg::res_t NoRes        = '0;
	localparam ccfr_pkg::res_t VerdOk       =
		'{ccfr_pkg::KIND_VERDICT, 8'h00, 16'h0000, ccfr_pkg::V_OK};
	localparam ccfr_pkg::res_t VerdBadStart =
		'{ccfr_pkg::KIND_VERDICT, 8'h00, 16'h0000, ccfr_pkg::V_BAD_START};
	localparam ccfr_pkg::res_t VerdBadLen   =
		'{ccfr_pkg::KIND_VERDICT, 8'h00, 16'h0000, ccfr_pkg::V_BAD_LEN};
	localparam ccfr_pkg::res_t VerdBadEnd   =
		'{ccfr_pkg::KIND_VERDICT, 8'h00, 16'h0000, ccfr_pkg::V_BAD_END};

	logic                          clk       = 1'b0;
	logic                          arst_n    = 1'b0;
	logic                          s_tvalid  = 1'b0;
	logic                          s_tready;
	logic [ccfr_pkg::DataW-1:0]    s_tdata   = '0;    // [7:0] rx_byte
	logic                          m_tvalid;
	logic                          m_tready  = 1'b0;
	logic [ccfr_pkg::OutDataW-1:0] m_tdata;           // [7:0] data_byte, [23:8] byte_index,
	                                                  // [26:24] verdict, [31:27] zero
	logic                          m_tuser;           // [0] kind
	logic                          cfg_valid = 1'b0;
	logic                          cfg_ready;
	logic [ccfr_pkg::CfgIdxW-1:0]  cfg_index = '0;
	logic [ccfr_pkg::WordW-1:0]    cfg_data  = '0;

	// parser mirror
	ccfr_pkg::cfg_t rx_cfg;
	phase_e         ph;
	logic [1:0]     fld_cnt;
	logic [31:0]    fld_sr;
	logic [15:0]    pay_cnt;
	logic [31:0]    crc_run;

	ccfr_pkg::res_t parsed_q[$];
	int unsigned fail_cnt  = 0;
	int unsigned res_seen  = 0;
	int unsigned items_sent = 0;
	int unsigned idle_cyc  = 0;
	int unsigned rx_hold   = 0;
	int unsigned press_left = 2;
	int unsigned press_at  = 100;
	bit          rx_burst  = 1'b0;
	bit          tx_burst  = 1'b0;

	row_t dir_tab [DirRows] = '{
		'{1'b0, 2'd0, 16'h0000, 1'b1, 1'b0, NoRes},
		'{1'b0, 2'd0, 16'h0000, 1'b1, 1'b1, VerdBadStart},
		'{1'b0, 2'd0, 16'h0055, 1'b1, 1'b0, NoRes},
		'{1'b0, 2'd0, 16'h00AA, 1'b1, 1'b0, NoRes},
		'{1'b0, 2'd0, 16'h00FF, 1'b1, 1'b0, NoRes},
		'{1'b0, 2'd0, 16'h00FF, 1'b1, 1'b1, VerdBadLen},
		// empty payload: CRC field of zero matches
		'{1'b1, ccfr_pkg::CFG_EXP_LENGTH, 16'd0, 1'b1, 1'b0, NoRes},
		'{1'b0, 2'd0, 16'h0055, 1'b1, 1'b0, NoRes},
		'{1'b0, 2'd0, 16'h00AA, 1'b1, 1'b0, NoRes},
		'{1'b0, 2'd0, 16'h0000, 1'b1, 1'b0, NoRes},
		'{1'b0, 2'd0, 16'h0000, 1'b1, 1'b0, NoRes},
		'{1'b0, 2'd0, 16'h0000, 1'b1, 1'b0, NoRes},
		'{1'b0, 2'd0, 16'h0000, 1'b1, 1'b0, NoRes},
		'{1'b0, 2'd0, 16'h0000, 1'b1, 1'b0, NoRes},
		'{1'b0, 2'd0, 16'h0000, 1'b1, 1'b0, NoRes},
		'{1'b0, 2'd0, 16'h00AA, 1'b1, 1'b0, NoRes},
		'{1'b0, 2'd0, 16'h0055, 1'b1, 1'b1, VerdOk},
		// one payload byte, wrong CRC and wrong end word: end word wins
		'{1'b1, ccfr_pkg::CFG_EXP_LENGTH, 16'd1, 1'b1, 1'b0, NoRes},
		'{1'b0, 2'd0, 16'h0055, 1'b1, 1'b0, NoRes},
		'{1'b0, 2'd0, 16'h00AA, 1'b1, 1'b0, NoRes},
		'{1'b0, 2'd0, 16'h0001, 1'b1, 1'b0, NoRes},
		'{1'b0, 2'd0, 16'h0000, 1'b1, 1'b0, NoRes},
		'{1'b0, 2'd0, 16'h0080, 1'b0, 1'b0, NoRes},
		'{1'b0, 2'd0, 16'h0000, 1'b1, 1'b0, NoRes},
		'{1'b0, 2'd0, 16'h0000, 1'b1, 1'b0, NoRes},
		'{1'b0, 2'd0, 16'h0000, 1'b1, 1'b0, NoRes},
		'{1'b0, 2'd0, 16'h0000, 1'b1, 1'b0, NoRes},
		'{1'b0, 2'd0, 16'h0000, 1'b1, 1'b0, NoRes},
		'{1'b0, 2'd0, 16'h0000, 1'b1, 1'b1, VerdBadEnd}
	};

	crc32_checked_frame_receiver_core u_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tuser   (m_tuser),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	always #5 clk = ~clk;

	function automatic logic [31:0] crc_step(input logic [31:0] c, input logic [7:0] b);
		logic [31:0] r;
		r = c ^ {24'h0, b};
		repeat (8) r = (r >> 1) ^ (ccfr_pkg::CrcPoly & {32{r[0]}});
		return r;
	endfunction

	function automatic void restart_hunt();
		ph      = PH_HUNT;
		fld_cnt = '0;
		fld_sr  = '0;
		pay_cnt = '0;
		crc_run = ccfr_pkg::CrcInit;
	endfunction

	function automatic bit close_frame(output ccfr_pkg::res_t r,
		input logic [ccfr_pkg::VerdW-1:0] v);
		r = '{ccfr_pkg::KIND_VERDICT, 8'h00, 16'h0000, v};
		restart_hunt();
		return 1'b1;
	endfunction

	// advance the mirror by one received byte; returns 1 when an output item is due
	function automatic bit parse_byte(input logic [7:0] b, output ccfr_pkg::res_t r);
		int unsigned need;
		int unsigned pos;
		logic [15:0] word;
		r = NoRes;
		if (ph == PH_PAY) begin
			r = '{ccfr_pkg::KIND_PAYLOAD, b, pay_cnt, ccfr_pkg::V_OK};
			crc_run = crc_step(crc_run, b);
			pay_cnt = pay_cnt + 16'd1;
			if (pay_cnt >= rx_cfg.expected_length || pay_cnt == 16'd0) begin
				ph      = PH_CRC;
				fld_cnt = '0;
				fld_sr  = '0;
			end
			return 1'b1;
		end
		need = (ph == PH_CRC) ? 4 : 2;
		pos = 32'(fld_cnt);
		fld_sr[8*pos +: 8] = b;
		if (pos + 1 < need) begin
			fld_cnt = 2'(pos + 1);
			return 1'b0;
		end
		fld_cnt = '0;
		word = fld_sr[15:0];
		case (ph)
			PH_LEN: begin
				fld_sr = '0;
				if (word != rx_cfg.expected_length)
					return close_frame(r, ccfr_pkg::V_BAD_LEN);
				pay_cnt = '0;
				crc_run = ccfr_pkg::CrcInit;
				ph = (word == 16'd0) ? PH_CRC : PH_PAY;
				return 1'b0;
			end
			PH_CRC: begin
				// fold received CRC into the running one: zero on match
				crc_run = fld_sr ^ ~crc_run;
				fld_sr  = '0;
				ph      = PH_END;
				return 1'b0;
			end
			PH_END: begin
				if (word != rx_cfg.end_word) return close_frame(r, ccfr_pkg::V_BAD_END);
				return close_frame(r, (crc_run != 32'h0) ? ccfr_pkg::V_CRC_ERR :
					ccfr_pkg::V_OK);
			end
			default: begin
				fld_sr = '0;
				if (word != rx_cfg.start_word)
					return close_frame(r, ccfr_pkg::V_BAD_START);
				ph = PH_LEN;
				return 1'b0;
			end
		endcase
	endfunction

	function automatic int unsigned pause_len();
		int unsigned r;
		r = $urandom_range(0, 99);
		if (r < 70) return $urandom_range(1, 3);
		if (r < 95) return $urandom_range(4, 10);
		return $urandom_range(20, 40);
	endfunction

	function automatic logic [15:0] pick_word();
		case ($urandom_range(0, 5))
			0: return 16'h0000;
			1: return 16'hFFFF;
			2: return ccfr_pkg::StartWordRst;
			3: return ccfr_pkg::EndWordRst;
			default: return 16'($urandom);
		endcase
	endfunction

	function automatic logic [15:0] pick_len();
		int unsigned r;
		r = $urandom_range(0, 99);
		if (r < 10) return 16'd0;
		if (r < 20) return 16'd1;
		if (r < 28) return 16'hFFFF;
		if (r < 38) return 16'($urandom_range(25, 65534));
		return 16'($urandom_range(2, 24));
	endfunction

	task automatic send_byte(input logic [7:0] b, input bit fixed, input bit fx_has,
		input ccfr_pkg::res_t fx_res);
		int unsigned    gap;
		bit             has;
		ccfr_pkg::res_t r;
		gap = (tx_burst || $urandom_range(0, 2) != 0) ? 0 : pause_len();
		if (gap != 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= b;
		do @(posedge clk); while (!s_tready);
		items_sent++;
		has = parse_byte(b, r);
		if (fixed) begin
			has = fx_has;
			r   = fx_res;
		end
		if (has) parsed_q.push_back(r);
	endtask

	task automatic write_reg(input logic [ccfr_pkg::CfgIdxW-1:0] idx,
		input logic [ccfr_pkg::WordW-1:0] val);
		s_tvalid <= 1'b0;
		while (parsed_q.size() != 0) @(posedge clk);
		// let header or CRC bytes still in the pipe retire
		repeat (4) @(posedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		case (idx)
			ccfr_pkg::CFG_START_WORD: rx_cfg.start_word      = val;
			ccfr_pkg::CFG_END_WORD:   rx_cfg.end_word        = val;
			ccfr_pkg::CFG_EXP_LENGTH: rx_cfg.expected_length = val;
			default: ;
		endcase
	endtask

	task automatic send_frame();
		int unsigned r;
		int unsigned n;
		logic [15:0] sw;
		logic [15:0] lw;
		logic [15:0] ew;
		logic [31:0] crc;
		logic [7:0]  pay[$];
		// re-align the hunt to a byte pair
		if (ph == PH_HUNT && fld_cnt == 2'd1) send_byte(8'($urandom), 1'b0, 1'b0, NoRes);
		tx_burst = ($urandom_range(0, 4) == 0);
		r = $urandom_range(0, 99);
		if (r < 12) begin
			repeat ($urandom_range(1, 5)) send_byte(8'($urandom), 1'b0, 1'b0, NoRes);
			return;
		end
		sw = rx_cfg.start_word;
		lw = rx_cfg.expected_length;
		ew = rx_cfg.end_word;
		if (r < 18)
			sw ^= 16'($urandom_range(1, 65535));
		else if (r < 24 || (32'(lw) > MaxPay && $urandom_range(0, 3) != 0))
			lw ^= 16'($urandom_range(1, 65535));
		n = (32'(lw) > MaxPay) ? MaxPay : 32'(lw);
		crc = ccfr_pkg::CrcInit;
		repeat (n) begin
			pay.push_back(8'($urandom));
			crc = crc_step(crc, pay[$]);
		end
		crc = ~crc;
		if (r >= 24 && r < 34) crc ^= ($urandom | 32'h1);
		if (r >= 34 && r < 42) ew ^= 16'($urandom_range(1, 65535));
		send_byte(sw[7:0], 1'b0, 1'b0, NoRes);
		send_byte(sw[15:8], 1'b0, 1'b0, NoRes);
		send_byte(lw[7:0], 1'b0, 1'b0, NoRes);
		send_byte(lw[15:8], 1'b0, 1'b0, NoRes);
		foreach (pay[i]) send_byte(pay[i], 1'b0, 1'b0, NoRes);
		for (int k = 0; k < 4; k++) send_byte(crc[8*k +: 8], 1'b0, 1'b0, NoRes);
		send_byte(ew[7:0], 1'b0, 1'b0, NoRes);
		send_byte(ew[15:8], 1'b0, 1'b0, NoRes);
	endtask

	task automatic cmp_field(input string what, input logic [31:0] e, input logic [31:0] a);
		if (a !== e) begin
			$display("%0t: %s mismatch: expected %0h, got %0h", $time, what, e, a);
			fail_cnt++;
		end
	endtask

	task automatic check_out();
		ccfr_pkg::res_t e;
		res_seen++;
		if (parsed_q.size() == 0) begin
			$display("%0t: unexpected item: expected none, got tuser %0h tdata %0h",
				$time, m_tuser, m_tdata);
			fail_cnt++;
			return;
		end
		e = parsed_q.pop_front();
		cmp_field("kind", 32'(e.kind), 32'(m_tuser));
		cmp_field("data_byte", 32'(e.data_byte), 32'(m_tdata[7:0]));
		cmp_field("byte_index", 32'(e.byte_index), 32'(m_tdata[23:8]));
		cmp_field("verdict", 32'(e.verdict), 32'(m_tdata[26:24]));
		cmp_field("tdata pad", 32'h0, 32'(m_tdata[31:27]));
	endtask

	// output side: check items, drive tready with random holds and two long ones
	always @(posedge clk) begin
		if (arst_n) begin
			if (m_tvalid && m_tready) check_out();
			if (rx_hold != 0) begin
				rx_hold  <= rx_hold - 1;
				m_tready <= 1'b0;
			end else if (press_left != 0 && res_seen >= press_at) begin
				rx_hold    <= 300;
				m_tready   <= 1'b0;
				press_left = press_left - 1;
				press_at   = res_seen + 300;
			end else if (!rx_burst && $urandom_range(0, 3) == 0) begin
				rx_hold  <= pause_len() - 1;
				m_tready <= 1'b0;
			end else begin
				m_tready <= 1'b1;
			end
			if ($urandom_range(0, 199) == 0) rx_burst <= ~rx_burst;
		end
	end

	always @(posedge clk) begin
		if (!arst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready) ||
			(cfg_valid && cfg_ready)) begin
			idle_cyc <= 0;
		end else if (idle_cyc >= IdleLimit) begin
			$display("%0t: no item moved for %0d cycles", $time, idle_cyc);
			$display("Test completed with failures");
			$finish;
		end else begin
			idle_cyc <= idle_cyc + 1;
		end
	end

	initial begin
		int unsigned ph_stop;
		int unsigned k;
		rx_cfg = '{ccfr_pkg::StartWordRst, ccfr_pkg::EndWordRst, ccfr_pkg::ExpLengthRst};
		restart_hunt();
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (dir_tab[i]) begin
			if (dir_tab[i].cfg_wr)
				write_reg(dir_tab[i].reg_idx, dir_tab[i].value);
			else
				send_byte(dir_tab[i].value[7:0], dir_tab[i].fixed, dir_tab[i].has_res,
					dir_tab[i].res);
		end

		k = 0;
		ph_stop = items_sent;
		while (items_sent < DirRows + RandItems) begin
			case (k)
				0: begin
					write_reg(ccfr_pkg::CFG_START_WORD, 16'h0000);
					write_reg(ccfr_pkg::CFG_END_WORD, 16'hFFFF);
					write_reg(ccfr_pkg::CFG_EXP_LENGTH, 16'd2);
				end
				1: begin
					write_reg(ccfr_pkg::CFG_START_WORD, 16'hFFFF);
					write_reg(ccfr_pkg::CFG_END_WORD, 16'h0000);
					write_reg(ccfr_pkg::CFG_EXP_LENGTH, 16'hFFFF);
				end
				default: begin
					write_reg(ccfr_pkg::CFG_START_WORD, pick_word());
					write_reg(ccfr_pkg::CFG_END_WORD, pick_word());
					write_reg(ccfr_pkg::CFG_EXP_LENGTH, pick_len());
				end
			endcase
			ph_stop = items_sent + 100;
			while (items_sent < ph_stop) send_frame();
			k++;
		end
		s_tvalid <= 1'b0;

		while (parsed_q.size() != 0) @(posedge clk);
		repeat (8) @(posedge clk);
		if (fail_cnt == 0) begin
			$display("Test completed successfully");
		end else begin
			$display("Test completed with failures");
		end
		$finish;
	end

endmodule
